### src/dwws_pkg.sv
// ----------------------------------------------------------------------------
// dwws_pkg
// Shared types, defaults and elaboration helpers for the distance weighted
// window smoother.
// ----------------------------------------------------------------------------
`default_nettype none

package dwws_pkg;

  // Default sizing
  localparam int HALF_WIDTH_DEF  = 16;
  localparam int SAMPLE_BITS_DEF = 16;

  // Taps summed per first-stage partial sum
  localparam int GROUP_TAPS = 8;

  // Front-end phase: taking samples, or draining the held tail of a stream
  typedef enum logic {
    PH_RUN,
    PH_FLUSH
  } phase_e;

  // Control carried alongside each result through the pipeline
  typedef struct packed {
    logic vld;     // stage holds a result
    logic smooth;  // result is a weighted average, else a plain sample
    logic last;    // final result of the stream
  } tok_t;

  // Weight of line position a (0 is the newest sample); centre weighs 1
  function automatic int tap_weight(input int a, input int hw);
    int k;
    k = a - hw;
    if (k == 0) begin
      return 1;
    end
    return (k < 0) ? -k : k;
  endfunction

  // Sum of weights, which is also the divisor
  function automatic int weight_total(input int hw);
    return hw * (hw + 1) + 1;
  endfunction

  // Width of the signed weighted sum (with a spare bit)
  function automatic int sum_width(input int hw, input int sb);
    return sb + $clog2(weight_total(hw)) + 1;
  endfunction

  // Number of first-stage partial sums
  function automatic int group_count(input int hw);
    return (2 * hw + 1 + GROUP_TAPS - 1) / GROUP_TAPS;
  endfunction

endpackage

`default_nettype wire

### src/distance_weighted_window_smoother.sv
// ----------------------------------------------------------------------------
// distance_weighted_window_smoother
// Streaming weighted moving average over 2*HALF_WIDTH+1 samples, weight |k|
// at offset k and 1 at the centre, rounded to nearest; stream edges pass.
// ----------------------------------------------------------------------------
// Results pass the partial-sum, sum, divide and output registers to m_axis.
// Throughput: one sample per cycle unless stalled; each of these registers
//   holds one result, and back-pressure ripples stage by stage.
// A last marker after HALF_WIDTH or more samples holds s_axis off while the
//   held tail drains through the delay line.
// Reset clears control and pipeline valids; the delay line is not cleared.
`default_nettype none

module distance_weighted_window_smoother #(
  parameter int HALF_WIDTH  = dwws_pkg::HALF_WIDTH_DEF,
  parameter int SAMPLE_BITS = dwws_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // input stream
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]   s_axis_tdata,  // sample_in
  input  wire logic                               s_axis_tlast,  // last_in
  // output stream
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]        m_axis_tdata,  // sample_out
  output logic                                    m_axis_tlast   // last_out
);

  localparam int NG    = dwws_pkg::group_count(HALF_WIDTH);
  localparam int SUM_W = dwws_pkg::sum_width(HALF_WIDTH, SAMPLE_BITS);
  localparam int TD_W  = ((SAMPLE_BITS + 7) / 8) * 8;

  dwws_pkg::tok_t           tok1, tok2, tok4;
  logic [SAMPLE_BITS-1:0]   val1, val2, res4;
  logic [NG-1:0][SUM_W-1:0] part1;
  logic [SUM_W-1:0]         sum2;
  logic                     rdy2, rdy3;

  // Output register
  logic                   out_vld_q;
  logic [SAMPLE_BITS-1:0] out_data_q;
  logic                   out_last_q;
  logic                   en_out;

  assign en_out = !out_vld_q || m_axis_tready;

  dwws_front #(
    .HALF_WIDTH  (HALF_WIDTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_sample_i (s_axis_tdata[SAMPLE_BITS-1:0]),
    .in_last_i   (s_axis_tlast),
    .in_ready_o  (s_axis_tready),
    .dn_ready_i  (rdy2),
    .tok_o       (tok1),
    .val_o       (val1),
    .part_o      (part1)
  );

  dwws_sum #(
    .HALF_WIDTH  (HALF_WIDTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_sum (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tok_i      (tok1),
    .val_i      (val1),
    .part_i     (part1),
    .ready_o    (rdy2),
    .dn_ready_i (rdy3),
    .tok_o      (tok2),
    .val_o      (val2),
    .sum_o      (sum2)
  );

  dwws_div #(
    .HALF_WIDTH  (HALF_WIDTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tok_i      (tok2),
    .val_i      (val2),
    .sum_i      (sum2),
    .ready_o    (rdy3),
    .dn_ready_i (en_out),
    .tok_o      (tok4),
    .res_o      (res4)
  );

  // Result register towards m_axis
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en_out) begin
      out_vld_q <= tok4.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_out) begin
      out_data_q <= res4;
      out_last_q <= tok4.last;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = TD_W'(out_data_q);
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

### src/dwws_front.sv
// ----------------------------------------------------------------------------
// dwws_front
// Sample delay line, stream position tracking, tail flush sequencing and the
// first pipeline stage of weighted partial sums.
// ----------------------------------------------------------------------------
`default_nettype none

module dwws_front #(
  parameter int HALF_WIDTH  = dwws_pkg::HALF_WIDTH_DEF,
  parameter int SAMPLE_BITS = dwws_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // incoming samples
  input  wire logic                     in_valid_i,
  input  wire logic [SAMPLE_BITS-1:0]   in_sample_i,
  input  wire logic                     in_last_i,
  output logic                          in_ready_o,
  // towards the sum stage
  input  wire logic                     dn_ready_i,
  output dwws_pkg::tok_t                tok_o,
  output logic [SAMPLE_BITS-1:0]        val_o,
  output logic [dwws_pkg::group_count(HALF_WIDTH)-1:0]
               [dwws_pkg::sum_width(HALF_WIDTH, SAMPLE_BITS)-1:0] part_o
);

  localparam int DEPTH  = 2 * HALF_WIDTH + 1;
  localparam int NG     = dwws_pkg::group_count(HALF_WIDTH);
  localparam int GT     = dwws_pkg::GROUP_TAPS;
  localparam int SUM_W  = dwws_pkg::sum_width(HALF_WIDTH, SAMPLE_BITS);
  localparam int SEEN_W = $clog2(2 * HALF_WIDTH + 1);
  localparam int CNT_W  = $clog2(HALF_WIDTH + 1);

  // Delay line, position 0 newest
  logic [SAMPLE_BITS-1:0] line_q [DEPTH];
  logic [SAMPLE_BITS-1:0] line_d [DEPTH];
  logic                   shift;

  // Control state
  dwws_pkg::phase_e phase_q, phase_d;
  logic [SEEN_W-1:0] seen_q, seen_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CNT_W-1:0]  held_q, held_d;

  // Stage one
  dwws_pkg::tok_t         tok1_q, tok_d;
  logic [SAMPLE_BITS-1:0] val1_q, val_d;
  logic [NG-1:0][SUM_W-1:0] part1_q, part_d;

  logic en1;
  logic is_head;   // one of the first HALF_WIDTH samples
  logic is_full;   // a full window stands behind this sample

  assign en1     = !tok1_q.vld || dn_ready_i;
  assign is_head = (seen_q < SEEN_W'(HALF_WIDTH));
  assign is_full = (seen_q == SEEN_W'(2 * HALF_WIDTH));

  // Next line contents: shift by one, newest sample at the front
  always_comb begin
    line_d[0] = in_sample_i;
    for (int i = 1; i < DEPTH; i++) begin
      line_d[i] = line_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift) begin
      line_q <= line_d;
    end
  end

  // Weighted taps of the shifted line, padded to whole groups
  logic [SUM_W-1:0] wtd [NG*GT];

  for (genvar i = 0; i < NG * GT; i++) begin : g_tap
    if (i < DEPTH) begin : g_live
      localparam int Wt = dwws_pkg::tap_weight(i, HALF_WIDTH);
      logic signed [SUM_W-1:0] tap_ext;
      assign tap_ext = SUM_W'(signed'(line_d[i]));
      assign wtd[i]  = SUM_W'(tap_ext * SUM_W'(Wt));
    end else begin : g_pad
      assign wtd[i] = '0;
    end
  end

  // Partial sums per group
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      part_d[g] = '0;
      for (int j = 0; j < GT; j++) begin
        part_d[g] = part_d[g] + wtd[g*GT+j];
      end
    end
  end

  // Request handling and flush sequencing
  always_comb begin
    phase_d    = phase_q;
    seen_d     = seen_q;
    cnt_d      = cnt_q;
    held_d     = held_q;
    shift      = 1'b0;
    tok_d      = '0;
    val_d      = in_sample_i;
    in_ready_o = 1'b0;
    unique case (phase_q)
      dwws_pkg::PH_RUN: begin
        in_ready_o = en1;
        if (in_valid_i && en1) begin
          shift        = 1'b1;
          tok_d.vld    = is_head || is_full;
          tok_d.smooth = is_full;
          tok_d.last   = in_last_i && is_head;
          if (in_last_i) begin
            seen_d = '0;
            if (!is_head) begin
              // tail still held: drain it through the fixed tap
              phase_d = dwws_pkg::PH_FLUSH;
              cnt_d   = CNT_W'(HALF_WIDTH - 1);
              held_d  = is_full ? CNT_W'(HALF_WIDTH)
                                : CNT_W'(seen_q - SEEN_W'(HALF_WIDTH) + SEEN_W'(1));
            end
          end else if (!is_full) begin
            seen_d = seen_q + SEEN_W'(1);
          end
        end
      end
      dwws_pkg::PH_FLUSH: begin
        // sample at line position cnt sits at the tap after the shifts so far
        if (en1) begin
          shift      = 1'b1;
          tok_d.vld  = (cnt_q < held_q);
          tok_d.last = (cnt_q == '0);
          val_d      = line_q[HALF_WIDTH-1];
          cnt_d      = cnt_q - CNT_W'(1);
          if (cnt_q == '0) begin
            phase_d = dwws_pkg::PH_RUN;
          end
        end
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= dwws_pkg::PH_RUN;
      seen_q  <= '0;
      cnt_q   <= '0;
      held_q  <= '0;
      tok1_q  <= '0;
    end else begin
      phase_q <= phase_d;
      seen_q  <= seen_d;
      cnt_q   <= cnt_d;
      held_q  <= held_d;
      if (en1) begin
        tok1_q <= tok_d;
      end
    end
  end

  // Stage one payload
  always_ff @(posedge clk_i) begin
    if (en1) begin
      val1_q  <= val_d;
      part1_q <= part_d;
    end
  end

  assign tok_o  = tok1_q;
  assign val_o  = val1_q;
  assign part_o = part1_q;

endmodule

`default_nettype wire

### src/dwws_sum.sv
// ----------------------------------------------------------------------------
// dwws_sum
// Second pipeline stage: adds the group partial sums into the full weighted
// window sum.
// ----------------------------------------------------------------------------
`default_nettype none

module dwws_sum #(
  parameter int HALF_WIDTH  = dwws_pkg::HALF_WIDTH_DEF,
  parameter int SAMPLE_BITS = dwws_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire dwws_pkg::tok_t         tok_i,
  input  wire logic [SAMPLE_BITS-1:0] val_i,
  input  wire logic [dwws_pkg::group_count(HALF_WIDTH)-1:0]
                    [dwws_pkg::sum_width(HALF_WIDTH, SAMPLE_BITS)-1:0] part_i,
  output logic                        ready_o,
  input  wire logic                   dn_ready_i,
  output dwws_pkg::tok_t              tok_o,
  output logic [SAMPLE_BITS-1:0]      val_o,
  output logic [dwws_pkg::sum_width(HALF_WIDTH, SAMPLE_BITS)-1:0] sum_o
);

  localparam int NG    = dwws_pkg::group_count(HALF_WIDTH);
  localparam int SUM_W = dwws_pkg::sum_width(HALF_WIDTH, SAMPLE_BITS);

  dwws_pkg::tok_t         tok_q;
  logic [SAMPLE_BITS-1:0] val_q;
  logic [SUM_W-1:0]       sum_q, sum_d;
  logic                   en;

  assign en      = !tok_q.vld || dn_ready_i;
  assign ready_o = en;

  // Total of the partial sums
  always_comb begin
    sum_d = '0;
    for (int g = 0; g < NG; g++) begin
      sum_d = sum_d + part_i[g];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else if (en) begin
      tok_q <= tok_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      val_q <= val_i;
      sum_q <= sum_d;
    end
  end

  assign tok_o = tok_q;
  assign val_o = val_q;
  assign sum_o = sum_q;

endmodule

`default_nettype wire

### src/dwws_div.sv
// ----------------------------------------------------------------------------
// dwws_div
// Rounded division of the weighted sum by the weight total: magnitude and
// rounding offset, reciprocal multiply, then a one-step correction and sign.
// ----------------------------------------------------------------------------
`default_nettype none

module dwws_div #(
  parameter int HALF_WIDTH  = dwws_pkg::HALF_WIDTH_DEF,
  parameter int SAMPLE_BITS = dwws_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire dwws_pkg::tok_t         tok_i,
  input  wire logic [SAMPLE_BITS-1:0] val_i,
  input  wire logic [dwws_pkg::sum_width(HALF_WIDTH, SAMPLE_BITS)-1:0] sum_i,
  output logic                        ready_o,
  input  wire logic                   dn_ready_i,
  output dwws_pkg::tok_t              tok_o,
  output logic [SAMPLE_BITS-1:0]      res_o
);

  localparam int SUM_W = dwws_pkg::sum_width(HALF_WIDTH, SAMPLE_BITS);
  localparam int N_W   = SUM_W;
  localparam int DIV   = dwws_pkg::weight_total(HALF_WIDTH);
  localparam int R_W   = N_W - $clog2(2 * DIV) + 1;
  // floor(2^N_W / (2*DIV)): quotient estimate is exact or one short
  localparam logic [R_W-1:0] RECIP = R_W'((64'd1 << N_W) / 64'(2 * DIV));
  localparam int SB    = SAMPLE_BITS;

  // Stage three: sign and rounded numerator 2|s| + DIV
  dwws_pkg::tok_t  tok3_q;
  logic [SB-1:0]   val3_q;
  logic            neg3_q;
  logic [N_W-1:0]  num3_q, num_d;
  logic [SUM_W-1:0] mag;
  logic            en3;

  // Stage four: quotient estimate
  dwws_pkg::tok_t  tok4_q;
  logic [SB-1:0]   val4_q;
  logic            neg4_q;
  logic [N_W-1:0]  num4_q;
  logic [SB-1:0]   q0_4_q;
  logic [N_W+R_W-1:0] prod;
  logic            en4;

  assign en4     = !tok4_q.vld || dn_ready_i;
  assign en3     = !tok3_q.vld || en4;
  assign ready_o = en3;

  assign mag   = sum_i[SUM_W-1] ? (SUM_W'(0) - sum_i) : sum_i;
  assign num_d = N_W'({mag, 1'b0}) + N_W'(DIV);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok3_q <= '0;
      tok4_q <= '0;
    end else begin
      if (en3) begin
        tok3_q <= tok_i;
      end
      if (en4) begin
        tok4_q <= tok3_q;
      end
    end
  end

  // Reciprocal multiply
  assign prod = (N_W+R_W)'(num3_q) * (N_W+R_W)'(RECIP);

  always_ff @(posedge clk_i) begin
    if (en3) begin
      val3_q <= val_i;
      neg3_q <= sum_i[SUM_W-1];
      num3_q <= num_d;
    end
    if (en4) begin
      val4_q <= val3_q;
      neg4_q <= neg3_q;
      num4_q <= num3_q;
      q0_4_q <= prod[N_W +: SB];
    end
  end

  // Correction: bump the estimate when the next multiple still fits
  logic [N_W:0]  q_up;
  logic [N_W:0]  bound;
  logic [SB-1:0] quo;
  logic [SB-1:0] avg;

  assign q_up  = (N_W+1)'(q0_4_q) + (N_W+1)'(1);
  assign bound = (N_W+1)'(q_up * (N_W+1)'(2 * DIV));
  assign quo   = q0_4_q + SB'({1'b0, num4_q} >= bound);
  assign avg   = neg4_q ? (SB'(0) - quo) : quo;

  assign tok_o = tok4_q;
  assign res_o = tok4_q.smooth ? avg : val4_q;

endmodule

`default_nettype wire

### bench/distance_weighted_window_smoother_test.sv
// ----------------------------------------------------------------------------
// distance_weighted_window_smoother_test
// Self-checking bench for the window smoother. A scoreboard predicts every
// smoothed and passed-through sample from the accepted requests. Results are
// checked in order, field by field. Streams of many lengths and value
// patterns are sent with random idling on both sides, and one long output
// hold-off makes the block back up to its input.
// ----------------------------------------------------------------------------
module distance_weighted_window_smoother_test;

  localparam int HW         = dwws_pkg::HALF_WIDTH_DEF;
  localparam int SB         = dwws_pkg::SAMPLE_BITS_DEF;
  localparam int DATA_W     = ((SB + 7) / 8) * 8;
  localparam int LINE_DEPTH = 2 * HW + 1;
  localparam int ITEM_GOAL  = 430;
  localparam int CALM_FROM  = 350;    // no idling past this many requests
  localparam int HOLD_AT    = 120;    // long output hold-off starts here
  localparam int HOLD_LEN   = 400;
  localparam int CYCLE_MAX  = 1000000;
  localparam int TAIL_WAIT  = 20;

  // Value patterns for a stream
  typedef enum int {
    PAT_RANDOM,
    PAT_MAX,
    PAT_MIN,
    PAT_SWING,
    PAT_NEAR_ZERO
  } pattern_e;

  typedef struct packed {
    logic [DATA_W-1:0] smp;
    logic              lst;
  } outcome_t;

  // Predicts the output stream and checks results against it
  class window_scoreboard;
    longint      taps[LINE_DEPTH];   // entry 0 is the newest sample
    int unsigned seen;
    outcome_t    due_q[$];
    int          errors;

    function new();
      foreach (taps[a]) taps[a] = 0;
      seen   = 0;
      errors = 0;
    endfunction

    // Weighted mean of the full window, rounded half away from zero
    function logic [DATA_W-1:0] weighted_mean();
      longint acc, mag, q, w, k, total;
      acc   = 0;
      total = HW * (HW + 1) + 1;
      for (int a = 0; a < LINE_DEPTH; a++) begin
        k   = a - HW;
        w   = (k == 0) ? 1 : ((k < 0) ? -k : k);
        acc += w * taps[a];
      end
      mag = (acc < 0) ? -acc : acc;
      q   = (2 * mag + total) / (2 * total);
      if (acc < 0) q = -q;
      return q[DATA_W-1:0];
    endfunction

    function void push_due(logic [DATA_W-1:0] smp, logic lst);
      outcome_t o;
      o.smp = smp;
      o.lst = lst;
      due_q.push_back(o);
    endfunction

    // Accepted request: shift the line and queue what it causes
    function void note_request(logic [DATA_W-1:0] smp, logic lst);
      int unsigned idx;
      int          held;
      longint      x;
      idx = seen;
      x   = $signed(smp[SB-1:0]);
      for (int a = LINE_DEPTH - 1; a > 0; a--) taps[a] = taps[a-1];
      taps[0] = x;
      if (idx < HW) begin
        push_due(smp, lst);
      end else if (idx >= 2 * HW) begin
        push_due(weighted_mean(), 1'b0);
      end
      // last marker drains the held tail unchanged
      if (lst && idx >= HW) begin
        held = (idx >= 2 * HW) ? HW : int'(idx) - HW + 1;
        for (int a = held - 1; a >= 0; a--) push_due(taps[a][DATA_W-1:0], a == 0);
      end
      if (lst) begin
        seen = 0;
      end else if (idx < 2 * HW) begin
        seen = idx + 1;
      end
    endfunction

    function void check_result(logic [DATA_W-1:0] smp, logic lst);
      outcome_t want;
      if (due_q.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %0d/%0b",
                 $time, $signed(smp), lst);
        errors++;
        return;
      end
      want = due_q.pop_front();
      if (want.smp !== smp) begin
        $display("%0t: sample_out mismatch, expected %0d actual %0d",
                 $time, $signed(want.smp), $signed(smp));
        errors++;
      end
      if (want.lst !== lst) begin
        $display("%0t: last_out mismatch, expected %0b actual %0b",
                 $time, want.lst, lst);
        errors++;
      end
    endfunction

    function int pending();
      return due_q.size();
    endfunction
  endclass

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [DATA_W-1:0] s_axis_tdata  = '0;  // sample_in
  logic              s_axis_tlast  = 1'b0; // last_in
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [DATA_W-1:0] m_axis_tdata;        // sample_out
  logic              m_axis_tlast;        // last_out

  window_scoreboard board;
  int  samples_taken = 0;
  int  samples_sent  = 0;
  bit  idle_on       = 1'b1;
  int  tx_idle_odds  = 2;     // out of 8
  int  rx_idle_odds  = 2;     // out of 8
  bit  hold_done     = 1'b0;
  int  cycles        = 0;

  distance_weighted_window_smoother #(
    .HALF_WIDTH  (HW),
    .SAMPLE_BITS (SB)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Offer one request, with an optional idle burst first
  task automatic send_sample(input logic [DATA_W-1:0] smp, input logic lst);
    if (idle_on && $urandom_range(0, 7) < tx_idle_odds) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    s_axis_tlast  <= lst;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_request(smp, lst);
    samples_taken++;
  endtask

  function automatic logic [DATA_W-1:0] pattern_value(pattern_e pat, int i);
    case (pat)
      PAT_MAX:       return DATA_W'(16'sh7fff);
      PAT_MIN:       return DATA_W'(16'sh8000);
      PAT_SWING:     return (i % 2) ? DATA_W'(16'sh7fff) : DATA_W'(16'sh8000);
      PAT_NEAR_ZERO: return DATA_W'($urandom_range(0, 6) - 3);
      default:       return DATA_W'($urandom());
    endcase
  endfunction

  // Send a whole stream, last marker on its final sample
  task automatic send_stream(input int len, input pattern_e pat);
    for (int i = 0; i < len; i++) begin
      send_sample(pattern_value(pat, i), i == len - 1);
      samples_sent++;
      if (samples_sent >= CALM_FROM) idle_on = 1'b0;
    end
  endtask

  // Receiver: random stalls, plus one long hold-off mid-run
  initial begin
    forever begin
      if (!hold_done && samples_taken >= HOLD_AT) begin
        hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk_i);
      end else if (idle_on && $urandom_range(0, 7) < rx_idle_odds) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      board.check_result(m_axis_tdata, m_axis_tlast);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_MAX) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Main sequence
  initial begin
    int       len;
    int       pick;
    pattern_e pat;
    board = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: single-sample stream, two-sample stream, and a short stream
    // one past the pass-through head so exactly one sample is held
    send_sample(DATA_W'(16'sh8000), 1'b1);
    send_sample(DATA_W'(16'sh7fff), 1'b0);
    send_sample(DATA_W'(16'sh0000), 1'b1);
    send_stream(HW + 1, PAT_SWING);
    samples_sent = 0;

    // Random streams, mostly long enough to reach the averages
    while (samples_sent < ITEM_GOAL - 3 - (HW + 1)) begin
      pick = $urandom_range(0, 9);
      if (pick < 3) begin
        len = $urandom_range(1, 2 * HW);
      end else if (pick == 3) begin
        len = 2 * HW + 1;
      end else if (pick < 9) begin
        len = $urandom_range(2 * HW + 2, 4 * HW);
      end else begin
        len = $urandom_range(4 * HW + 1, 6 * HW);
      end
      pick = $urandom_range(0, 9);
      case (pick)
        0:       pat = PAT_MAX;
        1:       pat = PAT_MIN;
        2:       pat = PAT_SWING;
        3:       pat = PAT_NEAR_ZERO;
        default: pat = PAT_RANDOM;
      endcase
      tx_idle_odds = $urandom_range(0, 3);
      rx_idle_odds = $urandom_range(0, 3);
      send_stream(len, pat);
    end
    s_axis_tvalid <= 1'b0;

    // Drain and let the pipeline settle
    while (board.pending() != 0) @(posedge clk_i);
    repeat (TAIL_WAIT) @(posedge clk_i);

    if (board.errors == 0 && board.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### sim.f
src/dwws_pkg.sv
src/dwws_front.sv
src/dwws_sum.sv
src/dwws_div.sv
src/distance_weighted_window_smoother.sv
bench/distance_weighted_window_smoother_test.sv
